@@ rtl/core/srpb_pkg.sv @@
// Shared types, codes and port widths of the record/playback row buffer.
package srpb_pkg;

  // Port field widths
  localparam int SAMPLE_W    = 32;
  localparam int STAMP_W     = 32;
  localparam int ROW_IDX_W   = 8;
  localparam int ROWS_HELD_W = 9;
  localparam int RUN_ST_W    = 2;
  localparam int OP_W        = 3;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_FIELD_W = SAMPLE_W + STAMP_W + ROW_IDX_W + ROWS_HELD_W + RUN_ST_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  // Event codes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_START  = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
  localparam logic [OP_W-1:0] OP_PAUSE  = 3'd3;
  localparam logic [OP_W-1:0] OP_RESUME = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ROWS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RECORD_MODE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_MODE   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_USE_TIME    = 2'd3;

  // Run state as seen on the result channel
  typedef enum logic [RUN_ST_W-1:0] {
    RS_IDLE  = 2'd0,
    RS_RUN   = 2'd1,
    RS_PAUSE = 2'd2
  } run_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the input transfer
    logic rec_tick;    // record the sample at the current row
    logic empty_tick;  // running tick on an empty store
    logic pb_start;    // read the current row to begin playback
    logic pb_next;     // advance the time scan by one row
    logic plain_fin;   // finish a one-row playback tick
    logic time_fin;    // finish a time-mode playback tick
    logic apply_op;    // apply a non-running event
    logic show_rd;     // read the current row for display
    logic show_fin;    // latch the displayed row
    logic out_load;    // move the result into the output register
  } srpb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic run_tick;    // captured event is a tick while running
    logic record;      // record mode
    logic empty;       // no rows held
    logic use_time;    // time-mode playback
    logic scan_more;   // time scan must go on to the next row
    logic out_busy;    // output register holds a result not taken
  } srpb_status_t;

endpackage

@@ rtl/core/srpb_ctrl.sv @@
// Sequencing state machine of the record/playback row buffer.
module srpb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_ready,
  input  srpb_pkg::srpb_status_t st,
  output srpb_pkg::srpb_cmd_t    cmd
);
  import srpb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHOW_RD,
    S_SHOW_CHK,
    S_PB_CHK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  // Decode state and status into commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.run_tick) begin
          if (st.record) begin
            cmd.rec_tick = 1'b1;
            state_nxt    = S_DONE;
          end else if (st.empty) begin
            cmd.empty_tick = 1'b1;
            state_nxt      = S_DONE;
          end else begin
            cmd.pb_start = 1'b1;
            state_nxt    = S_PB_CHK;
          end
        end else begin
          cmd.apply_op = 1'b1;
          state_nxt    = S_SHOW_RD;
        end
      end
      S_SHOW_RD: begin
        cmd.show_rd = 1'b1;
        state_nxt   = S_SHOW_CHK;
      end
      S_SHOW_CHK: begin
        cmd.show_fin = 1'b1;
        state_nxt    = S_DONE;
      end
      S_PB_CHK: begin
        if (!st.use_time) begin
          cmd.plain_fin = 1'b1;
          state_nxt     = S_DONE;
        end else if (st.scan_more) begin
          cmd.pb_next = 1'b1;
        end else begin
          cmd.time_fin = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

@@ rtl/core/srpb_datapath.sv @@
// Row store, run state registers and result registers of the row buffer.
module srpb_datapath #(
  parameter int MAX_ROWS   = 256,
  parameter int DATA_WIDTH = 32,
  parameter int TIME_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input transfer payload
  input  logic [srpb_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [srpb_pkg::IN_TUSER_W-1:0]      in_tuser,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [srpb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [srpb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [srpb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // controller link
  input  srpb_pkg::srpb_cmd_t                  cmd,
  output srpb_pkg::srpb_status_t               st
);
  import srpb_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int DW = DATA_WIDTH;
  localparam int TW = TIME_WIDTH;

  // Clamp the row limit register to 1..MAX_ROWS
  function automatic logic [CW-1:0] clamp_rows(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return CW'(1);
    else if (32'(v) > MAX_ROWS) return CW'(MAX_ROWS);
    else return CW'(v);
  endfunction

  // Configuration registers
  logic [CFG_DATA_W-1:0] max_rows_r, max_rows_nxt;
  logic                  record_r, record_nxt;
  logic                  loop_r, loop_nxt;
  logic                  use_time_r, use_time_nxt;

  // Run state
  run_state_t            mode_r, mode_nxt;
  logic [AW-1:0]         cur_row_r, cur_row_nxt;
  logic [CW-1:0]         valid_r, valid_nxt;
  logic [TW-1:0]         elapsed_r, elapsed_nxt;
  logic                  once_r, once_nxt;

  // Captured input item
  logic [OP_W-1:0]       op_r;
  logic                  once_in_r;
  logic [DW-1:0]         sample_r;

  // Playback scan and result
  logic [AW-1:0]         scan_r, scan_nxt;
  logic [DW-1:0]         res_d_r, res_d_nxt;
  logic [TW-1:0]         res_s_r, res_s_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Row store
  logic [DW+TW-1:0]      mem [MAX_ROWS];
  logic [DW+TW-1:0]      rd_data_r;
  logic                  rd_ok_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [DW+TW-1:0]      wr_data;

  // Shared terms
  logic [CW-1:0]         eff_m;
  logic [CW-1:0]         r1;
  logic [AW-1:0]         scan_inc;
  logic [DW-1:0]         d_cur;
  logic [TW-1:0]         s_cur;
  logic [TW-1:0]         rec_stamp;

  assign eff_m     = clamp_rows(max_rows_r);
  assign r1        = CW'(cur_row_r) + CW'(1);
  assign scan_inc  = scan_r + AW'(1);
  assign d_cur     = rd_ok_r ? rd_data_r[DW-1:0] : '0;
  assign s_cur     = rd_ok_r ? rd_data_r[DW+TW-1:DW] : '0;
  assign rec_stamp = use_time_r ? elapsed_r : '0;

  // Status to the controller
  assign st.run_tick  = (op_r == OP_TICK) && (mode_r == RS_RUN);
  assign st.record    = record_r;
  assign st.empty     = (valid_r == '0);
  assign st.use_time  = use_time_r;
  assign st.scan_more = (s_cur < elapsed_r) && ((CW'(scan_r) + CW'(1)) < valid_r);
  assign st.out_busy  = out_valid_r && !out_tready;

  // Store port selection
  assign wr_en   = cmd.rec_tick;
  assign wr_data = {rec_stamp, sample_r};
  assign rd_en   = cmd.pb_start || cmd.pb_next || cmd.show_rd;
  assign rd_addr = cmd.pb_next ? scan_inc : cur_row_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state of the run registers
  always_comb begin
    logic [CW-1:0] m_cfg;
    logic [CW-1:0] v_cfg;
    logic [CW-1:0] c_cfg;
    logic          tick_done;
    logic          restart;

    max_rows_nxt  = max_rows_r;
    record_nxt    = record_r;
    loop_nxt      = loop_r;
    use_time_nxt  = use_time_r;
    mode_nxt      = mode_r;
    cur_row_nxt   = cur_row_r;
    valid_nxt     = valid_r;
    elapsed_nxt   = elapsed_r;
    once_nxt      = once_r;
    scan_nxt      = scan_r;
    res_d_nxt     = res_d_r;
    res_s_nxt     = res_s_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tick_done     = 1'b0;
    restart       = 1'b0;
    m_cfg         = clamp_rows(cfg_wdata);
    v_cfg         = (valid_r > m_cfg) ? m_cfg : valid_r;
    c_cfg         = CW'(cur_row_r);
    if (c_cfg > v_cfg) c_cfg = v_cfg;
    if (c_cfg > m_cfg - CW'(1)) c_cfg = m_cfg - CW'(1);

    if (cfg_we) begin
      // Register writes must arrive only while no item is in flight; the block does not enforce it
      case (cfg_index)
        REG_MAX_ROWS: begin
          max_rows_nxt = cfg_wdata;
          mode_nxt     = RS_IDLE;
          valid_nxt    = v_cfg;
          cur_row_nxt  = AW'(c_cfg);
        end
        REG_RECORD_MODE: begin
          if (cfg_wdata[0] && !record_r) cur_row_nxt = '0;
          record_nxt = cfg_wdata[0];
        end
        REG_LOOP_MODE: begin
          loop_nxt = cfg_wdata[0];
        end
        REG_USE_TIME: begin
          mode_nxt     = RS_IDLE;
          use_time_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end else if (cmd.rec_tick) begin
      // Record at the current row, then advance, wrap or stop at the limit
      res_d_nxt = sample_r;
      res_s_nxt = rec_stamp;
      if ((r1 >= valid_r) && (valid_r < CW'(MAX_ROWS))) valid_nxt = valid_r + CW'(1);
      if (r1 >= eff_m) begin
        if (loop_r) begin
          cur_row_nxt = '0;
        end else begin
          cur_row_nxt = AW'(eff_m - CW'(1));
          mode_nxt    = RS_PAUSE;
        end
      end else begin
        cur_row_nxt = AW'(r1);
      end
      tick_done = 1'b1;
    end else if (cmd.empty_tick) begin
      res_d_nxt   = '0;
      res_s_nxt   = '0;
      cur_row_nxt = '0;
      tick_done   = 1'b1;
    end else if (cmd.pb_start) begin
      scan_nxt = cur_row_r;
    end else if (cmd.pb_next) begin
      scan_nxt = scan_inc;
    end else if (cmd.plain_fin) begin
      // One row per tick, wrap or hold at the last row
      res_d_nxt = d_cur;
      res_s_nxt = s_cur;
      if (r1 >= valid_r) cur_row_nxt = loop_r ? '0 : AW'(valid_r - CW'(1));
      else cur_row_nxt = AW'(r1);
      tick_done = 1'b1;
    end else if (cmd.time_fin) begin
      // Scan ended on a row that is due, or ran off the end
      res_d_nxt = d_cur;
      res_s_nxt = s_cur;
      if (s_cur < elapsed_r) begin
        if (loop_r) begin
          cur_row_nxt = '0;
          restart     = 1'b1;
        end else begin
          cur_row_nxt = AW'(valid_r - CW'(1));
          mode_nxt    = RS_PAUSE;
        end
      end else begin
        cur_row_nxt = scan_r;
      end
      tick_done = 1'b1;
    end else if (cmd.apply_op) begin
      case (op_r)
        OP_START: begin
          mode_nxt    = RS_RUN;
          cur_row_nxt = '0;
          elapsed_nxt = '0;
          once_nxt    = once_in_r;
        end
        OP_STOP: begin
          mode_nxt = RS_IDLE;
        end
        OP_PAUSE: begin
          if (mode_r == RS_RUN) mode_nxt = RS_PAUSE;
        end
        OP_RESUME: begin
          if (mode_r == RS_PAUSE) begin
            mode_nxt = RS_RUN;
            once_nxt = once_in_r;
          end
        end
        OP_CLEAR: begin
          mode_nxt    = RS_IDLE;
          cur_row_nxt = '0;
          valid_nxt   = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.show_fin) begin
      // Show the current row unless idle
      res_d_nxt = (mode_r != RS_IDLE) ? d_cur : '0;
      res_s_nxt = (mode_r != RS_IDLE) ? s_cur : '0;
    end

    // Advance time and drop a pending single-step at the end of a tick
    if (tick_done) begin
      elapsed_nxt = restart ? '0 : elapsed_r + TW'(1);
      if (once_r) begin
        mode_nxt = RS_PAUSE;
        once_nxt = 1'b0;
      end
    end

    // Output register: load a finished result, clear on transfer
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {OUT_PAD_W'(0), mode_r, ROWS_HELD_W'(valid_r),
                       ROW_IDX_W'(cur_row_r), STAMP_W'(res_s_r), SAMPLE_W'(res_d_r)};
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and run state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rows_r  <= CFG_DATA_W'(8);
      record_r    <= 1'b0;
      loop_r      <= 1'b0;
      use_time_r  <= 1'b0;
      mode_r      <= RS_IDLE;
      cur_row_r   <= '0;
      valid_r     <= '0;
      elapsed_r   <= '0;
      once_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      max_rows_r  <= max_rows_nxt;
      record_r    <= record_nxt;
      loop_r      <= loop_nxt;
      use_time_r  <= use_time_nxt;
      mode_r      <= mode_nxt;
      cur_row_r   <= cur_row_nxt;
      valid_r     <= valid_nxt;
      elapsed_r   <= elapsed_nxt;
      once_r      <= once_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_tuser[OP_W-1:0];
      once_in_r <= in_tuser[OP_W];
      sample_r  <= DW'(in_tdata);
    end
    scan_r     <= scan_nxt;
    res_d_r    <= res_d_nxt;
    res_s_r    <= res_s_nxt;
    out_data_r <= out_data_nxt;
  end

  // Row store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[cur_row_r] <= wr_data;
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_ok_r   <= (CW'(rd_addr) < valid_r);
    end
  end

endmodule

@@ rtl/core/sample_record_playback_buffer_unit.sv @@
// A recording tick or an empty-store tick goes from the captured event straight to the
// result; a playback tick first reads the current row, other events read the row to show.
// The result then loads into the output register; in_tready returns as it loads, so one
// item is in work at a time. A time-mode playback tick scans one row at a time through the
// single registered read port of the row store, and a stalled result holds off the input.
// Reset (rst_n low, synchronous) idles the block, clears rows held, row and time.
module sample_record_playback_buffer_unit #(
  parameter int MAX_ROWS   = 256,
  parameter int DATA_WIDTH = 32,
  parameter int TIME_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input events
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [srpb_pkg::IN_TDATA_W-1:0]      in_tdata,   // [31:0] sample
  input  logic [srpb_pkg::IN_TUSER_W-1:0]      in_tuser,   // [2:0] op, [3] once
  // results
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] sample_out, [63:32] stamp_out, [71:64] row_index,
  // [80:72] rows_held, [82:81] run_state, [87:83] zero
  output logic [srpb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [srpb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [srpb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import srpb_pkg::*;

  srpb_cmd_t    cmd;
  srpb_status_t st;

  srpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_ready  (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  srpb_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .DATA_WIDTH (DATA_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

@@ rtl/core/srpb_checker.sv @@
// Port-level checks of the row buffer and their attachment to the top level.
module srpb_port_checks #(
  parameter int MAX_ROWS = 256
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [srpb_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import srpb_pkg::*;

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // One item at a time: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // Idle shows zero data and stamp
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[82:81] == RS_IDLE) |->
      (out_tdata[31:0] == '0) && (out_tdata[63:32] == '0))
    else $error("idle result carries row data");

  // Rows held never exceed the store depth
  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[80:72]) <= MAX_ROWS)
    else $error("rows held beyond store depth");

endmodule

bind sample_record_playback_buffer_unit srpb_port_checks #(.MAX_ROWS(MAX_ROWS))
  u_srpb_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/srpb_checker.sv @@
// Scoreboard for the record/playback row buffer: mirrors its state and checks every result.
`timescale 1ns / 100ps

module srpb_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [srpb_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] sample
  input  logic [srpb_pkg::IN_TUSER_W-1:0]   in_tuser,   // [2:0] op, [3] once
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] sample_out, [63:32] stamp_out, [71:64] row_index,
  // [80:72] rows_held, [82:81] run_state, [87:83] zero
  input  logic [srpb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [srpb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [srpb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                fail_count,
  output int                                results_due
);
  import srpb_pkg::*;

  localparam int ROW_CAP = 256;

  // One result transfer, laid out as on out_tdata
  typedef struct packed {
    logic [OUT_PAD_W-1:0]   pad;
    logic [RUN_ST_W-1:0]    state;
    logic [ROWS_HELD_W-1:0] held;
    logic [ROW_IDX_W-1:0]   row;
    logic [STAMP_W-1:0]     stamp;
    logic [SAMPLE_W-1:0]    data;
  } row_view_t;

  // Register copies
  logic [CFG_DATA_W-1:0] max_rows_reg;
  logic                  rec_mode;
  logic                  loop_mode;
  logic                  time_mode;

  // Block state copies
  run_state_t            run_st;
  int                    cur_row;
  int                    held_rows;
  logic [STAMP_W-1:0]    tick_count;
  logic                  once_armed;
  logic [SAMPLE_W-1:0]   kept_data  [ROW_CAP];
  logic [STAMP_W-1:0]    kept_stamp [ROW_CAP];

  row_view_t             views_due [$];

  // Rows the recorder may fill, clamped to the store size
  function automatic int row_limit();
    if (max_rows_reg == 0) return 1;
    if (max_rows_reg > ROW_CAP) return ROW_CAP;
    return int'(max_rows_reg);
  endfunction

  // Rows outside the held range read as zero
  function automatic void read_held(input int r, output logic [SAMPLE_W-1:0] d,
                                    output logic [STAMP_W-1:0] s);
    if (r < held_rows && r < ROW_CAP) begin
      d = kept_data[r];
      s = kept_stamp[r];
    end else begin
      d = '0;
      s = '0;
    end
  endfunction

  // Mirror a register write
  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] v);
    int m;
    case (idx)
      REG_MAX_ROWS: begin
        max_rows_reg = v;
        run_st = RS_IDLE;
        m = row_limit();
        if (held_rows > m) held_rows = m;
        if (cur_row > held_rows) cur_row = held_rows;
        if (cur_row > m - 1) cur_row = m - 1;
      end
      REG_RECORD_MODE: begin
        if (v[0] && !rec_mode) cur_row = 0;
        rec_mode = v[0];
      end
      REG_LOOP_MODE: loop_mode = v[0];
      REG_USE_TIME: begin
        run_st = RS_IDLE;
        time_mode = v[0];
      end
      default: ;
    endcase
  endfunction

  // Tick while running: record, or play back one row or a time scan
  function automatic void running_tick(input logic [SAMPLE_W-1:0] smp,
                                       output logic [SAMPLE_W-1:0] d,
                                       output logic [STAMP_W-1:0] s);
    logic [STAMP_W-1:0] t;
    bit                 restart;
    bit                 scanning;
    int                 r;
    int                 m;
    int                 steps;
    t = tick_count;
    restart = 1'b0;
    d = '0;
    s = '0;
    if (rec_mode) begin
      m = row_limit();
      r = cur_row;
      kept_data[r] = smp;
      kept_stamp[r] = time_mode ? t : '0;
      d = kept_data[r];
      s = kept_stamp[r];
      r++;
      if (r >= held_rows) held_rows++;
      if (held_rows > ROW_CAP) held_rows = ROW_CAP;
      if (r >= m) begin
        if (!loop_mode) begin
          r = m - 1;
          run_st = RS_PAUSE;
        end else begin
          r = 0;
        end
      end
      cur_row = r;
    end else if (held_rows == 0) begin
      cur_row = 0;
    end else if (time_mode) begin
      // Skip rows whose stamp is still below the elapsed count
      r = cur_row;
      steps = 0;
      read_held(r, d, s);
      scanning = (s < t);
      while (scanning && steps <= ROW_CAP) begin
        steps++;
        r++;
        if (r >= held_rows) begin
          if (!loop_mode) begin
            r = held_rows - 1;
            run_st = RS_PAUSE;
          end else begin
            r = 0;
            restart = 1'b1;
          end
          scanning = 1'b0;
        end else begin
          read_held(r, d, s);
          scanning = (s < t);
        end
      end
      cur_row = r;
    end else begin
      read_held(cur_row, d, s);
      r = cur_row + 1;
      if (r >= held_rows) r = loop_mode ? 0 : held_rows - 1;
      cur_row = r;
    end
    tick_count = restart ? '0 : t + 1'b1;
    if (once_armed) begin
      run_st = RS_PAUSE;
      once_armed = 1'b0;
    end
  endfunction

  // Advance the mirror by one event and build the result it must produce
  function automatic row_view_t predict_event(input logic [OP_W-1:0] op, input logic once,
                                              input logic [SAMPLE_W-1:0] smp);
    row_view_t           v;
    logic [SAMPLE_W-1:0] d;
    logic [STAMP_W-1:0]  s;
    bit                  shown;
    shown = 1'b0;
    d = '0;
    s = '0;
    case (op)
      OP_TICK: begin
        if (run_st == RS_RUN) begin
          running_tick(smp, d, s);
          shown = 1'b1;
        end
      end
      OP_START: begin
        run_st = RS_RUN;
        cur_row = 0;
        tick_count = '0;
        once_armed = once;
      end
      OP_STOP: run_st = RS_IDLE;
      OP_PAUSE: if (run_st == RS_RUN) run_st = RS_PAUSE;
      OP_RESUME: begin
        if (run_st == RS_PAUSE) begin
          run_st = RS_RUN;
          once_armed = once;
        end
      end
      OP_CLEAR: begin
        run_st = RS_IDLE;
        cur_row = 0;
        held_rows = 0;
      end
      default: ;
    endcase
    // Show the current row unless idle
    if (!shown && run_st != RS_IDLE) read_held(cur_row, d, s);
    v.pad   = '0;
    v.state = run_st;
    v.held  = held_rows[ROWS_HELD_W-1:0];
    v.row   = cur_row[ROW_IDX_W-1:0];
    v.stamp = s;
    v.data  = d;
    return v;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Compare results first, then mirror writes and new transfers of the same edge
  always @(posedge clk) begin
    row_view_t want;
    row_view_t got;
    if (!rst_n) begin
      max_rows_reg = 9'd8;
      rec_mode     = 1'b0;
      loop_mode    = 1'b0;
      time_mode    = 1'b0;
      run_st       = RS_IDLE;
      cur_row      = 0;
      held_rows    = 0;
      tick_count   = '0;
      once_armed   = 1'b0;
      fail_count   = 0;
      views_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (views_due.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result, expected none, got %h", $time, out_tdata);
        end else begin
          want = views_due.pop_front();
          check_field("sample_out", want.data, got.data);
          check_field("stamp_out", want.stamp, got.stamp);
          check_field("row_index", 32'(want.row), 32'(got.row));
          check_field("rows_held", 32'(want.held), 32'(got.held));
          check_field("run_state", 32'(want.state), 32'(got.state));
          check_field("padding", 32'(want.pad), 32'(got.pad));
        end
      end
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready)
        views_due.push_back(predict_event(in_tuser[OP_W-1:0], in_tuser[OP_W], in_tdata));
    end
    results_due = views_due.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the record/playback buffer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import srpb_pkg::*;

  // Event codes the block must ignore
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  // Receiver behaviors
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_HICCUP = 2;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;   // [31:0] sample
  logic [IN_TUSER_W-1:0]   in_tuser   = '0;   // [2:0] op, [3] once
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  // [31:0] sample_out, [63:32] stamp_out, [71:64] row_index,
  // [80:72] rows_held, [82:81] run_state, [87:83] zero
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata  = '0;
  int                      fail_count;
  int                      results_due;

  int                      burst_left = 0;
  int                      rx_mode    = RX_OPEN;
  int                      rx_span    = 0;
  int                      rx_hold    = 0;

  always #4 clk = ~clk;

  sample_record_playback_buffer_unit i_dut (.*);

  srpb_checker i_checker (.*);

  // Hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: switch between open, coin-flip and occasional long stalls
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(RX_OPEN, RX_HICCUP);
      rx_span = $urandom_range(20, 300);
    end
    rx_span--;
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: out_tready <= 1'b1;
        RX_COIN: out_tready <= ($urandom_range(0, 1) == 1);
        default: begin
          if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(4, 30);
          out_tready <= (rx_hold == 0);
        end
      endcase
    end
  end

  // Send one event; bursts of random length with random gaps between them
  task automatic send_event(input logic [OP_W-1:0] op, input logic once,
                            input logic [31:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(10, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= {once, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (results_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drain, then write all four registers; one-bit registers get random upper bits
  task automatic setup(input logic [CFG_DATA_W-1:0] rows, input bit rec, input bit wrap,
                       input bit timed);
    bit         rows_first;
    logic [7:0] junk;
    rows_first = 1'($urandom_range(0, 1));
    drain();
    if (rows_first) write_reg(REG_MAX_ROWS, rows);
    junk = 8'($urandom);
    write_reg(REG_RECORD_MODE, {junk, rec});
    junk = 8'($urandom);
    write_reg(REG_LOOP_MODE, {junk, wrap});
    junk = 8'($urandom);
    write_reg(REG_USE_TIME, {junk, timed});
    if (!rows_first) write_reg(REG_MAX_ROWS, rows);
  endtask

  // Mostly ticks, with pause/resume and the odd start, stop, clear or bad code
  task automatic random_event();
    int              pick;
    logic [OP_W-1:0] op;
    logic [31:0]     smp;
    pick = $urandom_range(0, 99);
    if (pick < 70)      op = OP_TICK;
    else if (pick < 76) op = OP_START;
    else if (pick < 79) op = OP_STOP;
    else if (pick < 87) op = OP_PAUSE;
    else if (pick < 97) op = OP_RESUME;
    else if (pick < 98) op = OP_CLEAR;
    else if (pick < 99) op = OP_RSVD_6;
    else                op = OP_RSVD_7;
    case ($urandom_range(0, 7))
      0:       smp = '0;
      1:       smp = '1;
      default: smp = $urandom;
    endcase
    send_event(op, ($urandom_range(0, 3) == 0), smp);
  endtask

  task automatic run_phase(input int count);
    send_event(OP_START, 1'b0, $urandom);
    repeat (count - 1) random_event();
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] rows;
    rows = 9'd256;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: idle tick, ignored codes, empty-store playback, wrong-state events
    send_event(OP_TICK, 1'b0, '1);
    send_event(OP_RSVD_6, 1'b1, '1);
    send_event(OP_RSVD_7, 1'b0, '0);
    send_event(OP_START, 1'b0, 32'h1234_5678);
    send_event(OP_TICK, 1'b0, 32'h8000_0001);
    send_event(OP_RESUME, 1'b1, '0);
    send_event(OP_PAUSE, 1'b0, '0);
    send_event(OP_PAUSE, 1'b0, '0);
    send_event(OP_RESUME, 1'b1, '0);
    send_event(OP_TICK, 1'b0, '1);
    send_event(OP_TICK, 1'b0, '1);
    send_event(OP_STOP, 1'b0, '0);
    send_event(OP_STOP, 1'b0, '0);
    send_event(OP_CLEAR, 1'b0, '0);

    // Record three timed rows without wrap: pause at the end, resume and overwrite
    setup(9'd3, 1'b1, 1'b0, 1'b1);
    send_event(OP_START, 1'b0, '0);
    send_event(OP_TICK, 1'b0, '1);
    send_event(OP_TICK, 1'b0, '0);
    send_event(OP_TICK, 1'b0, 32'hA5A5_A5A5);
    send_event(OP_TICK, 1'b0, 32'h5A5A_5A5A);
    send_event(OP_RESUME, 1'b0, '0);
    send_event(OP_TICK, 1'b0, 32'h7FFF_FFFE);

    // Time playback of those rows until it reaches the last one
    setup(9'd3, 1'b0, 1'b0, 1'b1);
    send_event(OP_START, 1'b0, '0);
    send_event(OP_TICK, 1'b0, '0);
    send_event(OP_TICK, 1'b0, '0);
    send_event(OP_TICK, 1'b0, '0);

    // Fill the whole store without stamps, wrapping past the end
    setup(9'd256, 1'b1, 1'b1, 1'b0);
    send_event(OP_START, 1'b0, '0);
    repeat (300) send_event(OP_TICK, 1'b0, $urandom);

    // Time playback over zero stamps: long scans that wrap and restart time
    setup(9'd256, 1'b0, 1'b1, 1'b1);
    run_phase(80);

    // Random settings, alternating mostly between recording and playback
    for (int ph = 0; ph < 18; ph++) begin
      if (ph == 0) begin
        rows = 9'd1;
      end else if (ph == 1) begin
        rows = 9'd2;
      end else if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0:       rows = 9'd1;
          1:       rows = 9'd2;
          2:       rows = 9'd256;
          3:       rows = 9'($urandom_range(0, 511));
          4, 5, 6: rows = 9'($urandom_range(1, 12));
          default: rows = 9'($urandom_range(1, 256));
        endcase
      end
      setup(rows, (ph % 2 == 0) ^ ($urandom_range(0, 4) == 0),
            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_phase(55);
    end

    drain();
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
